// ===== src/gpio_tmr_pkg.sv =====
// Shared types and constants for the GPIO and timer register block.
`default_nettype none

package gpio_tmr_pkg;

   localparam int PORT_WIDTH  = 32;
   localparam int WORD_WIDTH  = 32;
   localparam int ADDR_WIDTH  = 5;
   localparam int MHZ_WIDTH   = 12;
   localparam int PSC_WIDTH   = 15;
   localparam int TIMER_ON    = 15;

   localparam logic [MHZ_WIDTH-1:0] MHZ_RESET = MHZ_WIDTH'(20);

   localparam logic [ADDR_WIDTH-1:0] ADDR_PORTA   = 5'd0;
   localparam logic [ADDR_WIDTH-1:0] ADDR_DIRA    = 5'd2;
   localparam logic [ADDR_WIDTH-1:0] ADDR_PORTB   = 5'd4;
   localparam logic [ADDR_WIDTH-1:0] ADDR_DIRB    = 5'd6;
   localparam logic [ADDR_WIDTH-1:0] ADDR_COUNT   = 5'd8;
   localparam logic [ADDR_WIDTH-1:0] ADDR_STATUS  = 5'd10;
   localparam logic [ADDR_WIDTH-1:0] ADDR_CONTROL = 5'd12;
   localparam logic [ADDR_WIDTH-1:0] ADDR_PERIOD  = 5'd14;
   localparam logic [ADDR_WIDTH-1:0] ADDR_FREQ    = 5'd16;

   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 104;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] read_value;
      logic                  address_invalid;
      logic                  timer_wrapped;
      logic [WORD_WIDTH-1:0] port_a_pins;
      logic [WORD_WIDTH-1:0] port_b_pins;
   } result_type;

endpackage

`default_nettype wire

// ===== src/gpio_timer_register_block_unit.sv =====
// GPIO and timer register block: usage
//
// Each request transaction (req_*) is a register read, a register write or a
// timer tick, chosen by req_tuser. Every request yields exactly one response
// transaction (rsp_*) carrying the read data, the wrap flag of a tick and the
// two port values after the request; rsp_tuser flags a read of an unmapped
// address.
// A request is captured in an input register and executed once the output
// register is free, when its response is loaded into the output register;
// one request is taken each cycle while the receiver keeps rsp_tready high.
// If the receiver holds rsp_tready low, the output register holds its
// response and the input register holds one more request; req_tready drops
// only while both are full.
// csr_wr_en / csr_wr_data load the frequency register (MHz);
// write it only while no transaction is in flight.
// Synchronous reset clears all ports, directions, timer registers and the
// prescaler, sets the frequency register to 20 and empties both stages.
`default_nettype none

module gpio_timer_register_block_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_wr_en,
   input  wire logic [gpio_tmr_pkg::MHZ_WIDTH-1:0]      csr_wr_data,
   input  wire logic                                    req_tvalid,
   output      logic                                    req_tready,
   // [4:0] reg_address, [36:5] write_value, [39:37] zero
   input  wire logic [gpio_tmr_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // [1:0] opcode
   input  wire logic [1:0]                              req_tuser,
   output      logic                                    rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // [31:0] read_value, [32] timer_wrapped, [64:33] port_a_pins,
   // [96:65] port_b_pins, [103:97] zero
   output      logic [gpio_tmr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // [0] address_invalid
   output      logic                                    rsp_tuser
);
   import gpio_tmr_pkg::*;

   logic                  in_valid_ff;
   logic [1:0]            in_op_ff;
   logic [ADDR_WIDTH-1:0] in_addr_ff;
   logic [WORD_WIDTH-1:0] in_data_ff;
   logic                  out_valid_ff;
   result_type            out_ff;
   result_type            result;
   logic                  out_free;
   logic                  exec;
   logic                  take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign exec       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   gpio_tmr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .exec        (exec),
      .opcode      (in_op_ff),
      .reg_address (in_addr_ff),
      .write_value (in_data_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_tuser;
         in_addr_ff <= req_tdata[ADDR_WIDTH-1:0];
         in_data_ff <= req_tdata[ADDR_WIDTH +: WORD_WIDTH];
      end
      if (exec) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.address_invalid;
   assign rsp_tdata  = {7'd0, out_ff.port_b_pins, out_ff.port_a_pins,
                        out_ff.timer_wrapped, out_ff.read_value};

endmodule

`default_nettype wire

// ===== src/gpio_tmr_core.sv =====
// Register file, port write masking and timer update for one transaction.
`default_nettype none

module gpio_tmr_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [gpio_tmr_pkg::MHZ_WIDTH-1:0]  csr_wr_data,
   input  wire logic                                exec,
   input  wire logic [1:0]                          opcode,
   input  wire logic [gpio_tmr_pkg::ADDR_WIDTH-1:0] reg_address,
   input  wire logic [gpio_tmr_pkg::WORD_WIDTH-1:0] write_value,
   output gpio_tmr_pkg::result_type                 result
);
   import gpio_tmr_pkg::*;

   logic [MHZ_WIDTH-1:0]  clock_mhz_ff;
   logic [PORT_WIDTH-1:0] port_a_ff, port_a_in;
   logic [PORT_WIDTH-1:0] dir_a_ff, dir_a_in;
   logic [PORT_WIDTH-1:0] port_b_ff, port_b_in;
   logic [PORT_WIDTH-1:0] dir_b_ff, dir_b_in;
   logic [WORD_WIDTH-1:0] count_ff, count_in;
   logic [WORD_WIDTH-1:0] status_ff, status_in;
   logic [WORD_WIDTH-1:0] control_ff, control_in;
   logic [WORD_WIDTH-1:0] period_ff, period_in;
   logic [PSC_WIDTH-1:0]  psc_ff, psc_in;

   logic [PORT_WIDTH-1:0] wdata;
   logic [PSC_WIDTH-1:0]  psc_inc;
   logic [WORD_WIDTH-1:0] count_inc;
   logic [WORD_WIDTH-1:0] rd;
   logic                  bad;
   logic                  wrapped;

   assign wdata     = write_value[PORT_WIDTH-1:0];
   assign psc_inc   = psc_ff + PSC_WIDTH'(1);
   assign count_inc = count_ff + WORD_WIDTH'(1);

   always_comb begin
      port_a_in  = port_a_ff;
      dir_a_in   = dir_a_ff;
      port_b_in  = port_b_ff;
      dir_b_in   = dir_b_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      control_in = control_ff;
      period_in  = period_ff;
      psc_in     = psc_ff;
      rd         = '0;
      bad        = 1'b0;
      wrapped    = 1'b0;
      case (opcode_type'(opcode))
         OP_READ: begin
            case (reg_address)
               ADDR_PORTA:   rd = WORD_WIDTH'(port_a_ff);
               ADDR_DIRA:    rd = WORD_WIDTH'(dir_a_ff);
               ADDR_PORTB:   rd = WORD_WIDTH'(port_b_ff);
               ADDR_DIRB:    rd = WORD_WIDTH'(dir_b_ff);
               ADDR_COUNT:   rd = count_ff;
               ADDR_STATUS:  rd = status_ff;
               ADDR_CONTROL: rd = control_ff;
               ADDR_PERIOD:  rd = period_ff;
               ADDR_FREQ:    rd = WORD_WIDTH'(clock_mhz_ff);
               default:      bad = 1'b1;
            endcase
         end
         OP_WRITE: begin
            // input bits (direction set) keep their stored value
            case (reg_address)
               ADDR_PORTA:   port_a_in  = (wdata & ~dir_a_ff) | (port_a_ff & dir_a_ff);
               ADDR_DIRA:    dir_a_in   = wdata;
               ADDR_PORTB:   port_b_in  = (wdata & ~dir_b_ff) | (port_b_ff & dir_b_ff);
               ADDR_DIRB:    dir_b_in   = wdata;
               ADDR_COUNT:   count_in   = write_value;
               ADDR_STATUS:  status_in  = write_value;
               ADDR_CONTROL: control_in = write_value;
               ADDR_PERIOD:  period_in  = write_value;
               default:      ;
            endcase
         end
         OP_TICK: begin
            if (control_ff[TIMER_ON]) begin
               psc_in = psc_inc;
               if (psc_inc == control_ff[PSC_WIDTH-1:0]) begin
                  psc_in   = '0;
                  count_in = count_inc;
                  if (count_inc == period_ff) begin
                     count_in     = '0;
                     status_in[0] = 1'b1;
                     wrapped      = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_mhz_ff <= MHZ_RESET;
         port_a_ff    <= '0;
         dir_a_ff     <= '0;
         port_b_ff    <= '0;
         dir_b_ff     <= '0;
         count_ff     <= '0;
         status_ff    <= '0;
         control_ff   <= '0;
         period_ff    <= '0;
         psc_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            clock_mhz_ff <= csr_wr_data;
         end
         if (exec) begin
            port_a_ff  <= port_a_in;
            dir_a_ff   <= dir_a_in;
            port_b_ff  <= port_b_in;
            dir_b_ff   <= dir_b_in;
            count_ff   <= count_in;
            status_ff  <= status_in;
            control_ff <= control_in;
            period_ff  <= period_in;
            psc_ff     <= psc_in;
         end
      end
   end

   assign result.read_value      = rd;
   assign result.address_invalid = bad;
   assign result.timer_wrapped   = wrapped;
   assign result.port_a_pins     = WORD_WIDTH'(port_a_in);
   assign result.port_b_pins     = WORD_WIDTH'(port_b_in);

endmodule

`default_nettype wire
